FILE: src/threshold_median_filter_3x3_unit_macros.svh
// Assertion macros shared by the verification checker of the filter unit.
// Depends on nothing; included by the checker file by its bare name.
`ifndef THRESHOLD_MEDIAN_FILTER_3X3_UNIT_MACROS_SVH
`define THRESHOLD_MEDIAN_FILTER_3X3_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tmf_pkg.sv
// Shared constants, payload types and compare functions of the switching median filter.
// Depends on nothing; every file but tmf_ram and the macros header refers to it by scoped names.
package tmf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int IDX_W      = $clog2(MAX_WIDTH);
  localparam int COL_W      = IDX_W;
  localparam int ROW_W      = 17;
  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int THR_W      = 8;
  localparam int WCMP_W     = (IDX_W + 1 > FW_W) ? IDX_W + 1 : FW_W;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int WIN_COLS   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(480);
  localparam logic [THR_W-1:0] THR_RESET = '0;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [COL_W-1:0]  col_cnt_t;
  typedef logic [ROW_W-1:0]  row_cnt_t;
  typedef logic [WCMP_W-1:0] wcmp_t;
  typedef logic [LINE_W-1:0] line_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH       = 2'd0,
    CFG_FRAME_HEIGHT      = 2'd1,
    CFG_REPLACE_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic mode;
    pix_t pixel_in;
  } in_item_t;

  typedef struct packed {
    pix_t pixel_out;
    logic last_of_run;
    logic end_of_frame;
  } out_item_t;

  // One window column, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // The same column sorted ascending.
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } triple_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(a, min2(b, c));
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(a, max2(b, c));
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic triple_t sort3(input column_t c);
    triple_t t;
    t.lo = min3(c.top, c.mid, c.bot);
    t.md = med3(c.top, c.mid, c.bot);
    t.hi = max3(c.top, c.mid, c.bot);
    return t;
  endfunction

endpackage

FILE: src/tmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; a read at the address being written returns the old data.
module tmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/tmf_cell.sv
// One window column cell: holds a column and its sorted form, hands the column on.
// Depends on tmf_pkg for the column types and the three-input sort.
module tmf_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  tmf_pkg::column_t  in_col,
  output tmf_pkg::column_t  col,
  output tmf_pkg::triple_t  srt
);

  tmf_pkg::column_t col_r;
  tmf_pkg::triple_t srt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      srt_r <= '0;
    end else if (en) begin
      col_r <= in_col;
      srt_r <= tmf_pkg::sort3(in_col);
    end
  end

  assign col = col_r;
  assign srt = srt_r;

endmodule

FILE: src/tmf_select.sv
// Merges three sorted columns into the 3x3 median and picks median or center.
// Depends on tmf_pkg for the triple type and the compare functions.
module tmf_select (
  input  tmf_pkg::triple_t           col_a,
  input  tmf_pkg::triple_t           col_b,
  input  tmf_pkg::triple_t           col_c,
  input  tmf_pkg::pix_t              center,
  input  logic [tmf_pkg::THR_W-1:0]  threshold,
  output tmf_pkg::pix_t              pix
);

  tmf_pkg::pix_t lo_max;
  tmf_pkg::pix_t md_med;
  tmf_pkg::pix_t hi_min;
  tmf_pkg::pix_t median;
  tmf_pkg::pix_t diff;

  // The median of nine is the median of the largest minimum, the median of
  // medians and the smallest maximum of any three sorted triples.
  always_comb begin
    lo_max = tmf_pkg::max3(col_a.lo, col_b.lo, col_c.lo);
    md_med = tmf_pkg::med3(col_a.md, col_b.md, col_c.md);
    hi_min = tmf_pkg::min3(col_a.hi, col_b.hi, col_c.hi);
    median = tmf_pkg::med3(lo_max, md_med, hi_min);
    diff   = (center > median) ? (center - median) : (median - center);
    pix    = (diff > threshold) ? median : center;
  end

endmodule

FILE: src/threshold_median_filter_3x3_unit.sv
// Switching 3x3 median filter top level; uses tmf_pkg, tmf_ram, tmf_cell, tmf_select.
// An item passes the line-store read stage, the window cells with the result stage, and the
//   output register; a second result of an item leaves after its first. Throughput: one item
//   per cycle unless out_stall holds the output; an item that ends a row and emits two results
//   holds the input until its second result is taken, as the output register takes one result a cycle.
// Reset (synchronous, rst_n low): counters and window cleared, registers to 640/480/0;
//   the line store is not cleared, so the block takes input as soon as reset is released.
module threshold_median_filter_3x3_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tmf_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tmf_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Per-item control that travels with the item from the line-store read
  // stage to the result stage.
  typedef struct packed {
    logic col0;        // first column: the window is loaded with replicated columns
    logic first_row;   // row 0: all three window rows are the incoming pixel
    logic second_row;  // row 1: the upper row replicates the middle row
    logic drain;       // drain row: the lower row replicates the middle row
    logic emit1;       // item produces the result one column behind it
    logic emit2;       // item ends a row and produces the last column's result
    logic last1;       // the first result is also the last of this item
  } item_ctl_t;

  // Configuration registers. Writes are always taken; the controller must only
  // write while the block is idle, which the block itself does not enforce.
  logic [tmf_pkg::FW_W-1:0]  frame_width_r;
  logic [tmf_pkg::FH_W-1:0]  frame_height_r;
  logic [tmf_pkg::THR_W-1:0] threshold_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= tmf_pkg::FW_RESET;
      frame_height_r <= tmf_pkg::FH_RESET;
      threshold_r    <= tmf_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmf_pkg::CFG_FRAME_WIDTH:       frame_width_r  <= cfg_data[tmf_pkg::FW_W-1:0];
        tmf_pkg::CFG_FRAME_HEIGHT:      frame_height_r <= cfg_data[tmf_pkg::FH_W-1:0];
        tmf_pkg::CFG_REPLACE_THRESHOLD: threshold_r    <= cfg_data[tmf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster position of the next input item. A width of zero acts as one and
  // a width beyond the line store acts as the line store's depth; a height
  // of zero acts as one. Comparing with >= lets a counter that is already
  // past a limit end its row or frame at once.
  tmf_pkg::col_cnt_t col_cnt_r;
  tmf_pkg::row_cnt_t row_cnt_r;
  tmf_pkg::wcmp_t    fw_ext;
  tmf_pkg::wcmp_t    w_eff;
  tmf_pkg::wcmp_t    col_inc;
  logic [tmf_pkg::FH_W-1:0] h_eff;
  logic              row_end;
  tmf_pkg::idx_t     rd_idx;
  tmf_pkg::pix_t     in_pix;
  item_ctl_t         in_ctl;
  logic              in_xfer;

  always_comb begin
    fw_ext  = tmf_pkg::wcmp_t'(frame_width_r);
    if (frame_width_r == '0) begin
      w_eff = tmf_pkg::wcmp_t'(1);
    end else if (fw_ext > tmf_pkg::wcmp_t'(tmf_pkg::MAX_WIDTH)) begin
      w_eff = tmf_pkg::wcmp_t'(tmf_pkg::MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff   = (frame_height_r == '0) ? tmf_pkg::FH_W'(1) : frame_height_r;
    col_inc = tmf_pkg::wcmp_t'(col_cnt_r) + tmf_pkg::wcmp_t'(1);
    row_end = (col_inc >= w_eff);
    if (tmf_pkg::wcmp_t'(col_cnt_r) < tmf_pkg::wcmp_t'(tmf_pkg::MAX_WIDTH)) begin
      rd_idx = col_cnt_r[tmf_pkg::IDX_W-1:0];
    end else begin
      rd_idx = tmf_pkg::idx_t'(tmf_pkg::MAX_WIDTH - 1);
    end
    // A drain item that arrives before the drain row counts as a black pixel.
    in_pix            = in_data.mode ? '0 : in_data.pixel_in;
    in_ctl.col0       = (col_cnt_r == '0);
    in_ctl.first_row  = (row_cnt_r == '0);
    in_ctl.second_row = (row_cnt_r == tmf_pkg::row_cnt_t'(1));
    in_ctl.drain      = (row_cnt_r >= tmf_pkg::row_cnt_t'(h_eff));
    in_ctl.emit1      = !in_ctl.first_row && !in_ctl.col0;
    in_ctl.emit2      = !in_ctl.first_row && row_end;
    in_ctl.last1      = !row_end;
  end

  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_xfer) begin
      if (row_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= in_ctl.drain ? '0 : row_cnt_r + tmf_pkg::row_cnt_t'(1);
      end else begin
        col_cnt_r <= col_cnt_r + tmf_pkg::col_cnt_t'(1);
      end
    end
  end

  // Line-store read stage. The two stored rows share one RAM word: the upper
  // row in the high byte, the middle row in the low byte. The read is issued
  // at the transfer and the word is rewritten when the item leaves this stage.
  logic              s1_valid_r;
  item_ctl_t         s1_ctl_r;
  tmf_pkg::idx_t     s1_idx_r;
  tmf_pkg::pix_t     s1_pix_r;
  logic              s1_adv;
  logic              s2_free;
  tmf_pkg::line_t    ram_rd_data;
  tmf_pkg::line_t    line_word;
  tmf_pkg::line_t    wr_word;
  tmf_pkg::pix_t     up_pix;
  tmf_pkg::pix_t     md_pix;
  tmf_pkg::column_t  new_col;
  logic              fwd_hit_r;
  tmf_pkg::line_t    fwd_data_r;

  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s1_adv;

  tmf_ram #(
    .WIDTH (tmf_pkg::LINE_W),
    .DEPTH (tmf_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx_r),
    .wr_data (wr_word),
    .rd_en   (in_xfer),
    .rd_addr (rd_idx),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    // With a one-pixel row, consecutive items hit the same word; the RAM then
    // returns the data from before the write, so the written word is bypassed.
    line_word = fwd_hit_r ? fwd_data_r : ram_rd_data;
    up_pix    = line_word[tmf_pkg::LINE_W-1:tmf_pkg::PIX_W];
    md_pix    = line_word[tmf_pkg::PIX_W-1:0];
    if (s1_ctl_r.first_row) begin
      new_col.top = s1_pix_r;
      new_col.mid = s1_pix_r;
      new_col.bot = s1_pix_r;
    end else begin
      new_col.top = s1_ctl_r.second_row ? md_pix : up_pix;
      new_col.mid = md_pix;
      new_col.bot = s1_ctl_r.drain ? md_pix : s1_pix_r;
    end
    // The middle row moves up, the new lower pixel becomes the middle row.
    wr_word = {md_pix, new_col.bot};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_adv && (s1_idx_r == rd_idx);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ctl_r   <= in_ctl;
      s1_idx_r   <= rd_idx;
      s1_pix_r   <= in_pix;
      fwd_data_r <= wr_word;
    end
  end

  // Window: three column cells, left to right. The new column enters the
  // rightmost cell and each cell passes its column to the left neighbor; at
  // the first column of a row every cell loads the new column, which
  // replicates the left border.
  tmf_pkg::column_t cell_in  [tmf_pkg::WIN_COLS];
  tmf_pkg::column_t cell_col [tmf_pkg::WIN_COLS];
  tmf_pkg::triple_t cell_srt [tmf_pkg::WIN_COLS];

  always_comb begin
    for (int k = 0; k < tmf_pkg::WIN_COLS - 1; k++) begin
      cell_in[k] = s1_ctl_r.col0 ? new_col : cell_col[k+1];
    end
    cell_in[tmf_pkg::WIN_COLS-1] = new_col;
  end

  for (genvar g = 0; g < tmf_pkg::WIN_COLS; g++) begin : g_cell
    tmf_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (s1_adv),
      .in_col (cell_in[g]),
      .col    (cell_col[g]),
      .srt    (cell_srt[g])
    );
  end

  // Result stage. The item whose column just entered the window produces up
  // to two results: the pixel one column behind it, and at a row end also the
  // last pixel of the row, whose window replicates the right border column.
  // The window stays put until the item's last result has moved on.
  logic           s2_valid_r;
  item_ctl_t      s2_ctl_r;
  logic           s2_sent1_r;
  logic           pend_first;
  logic           pend_any;
  logic           is_last;
  logic           out_load;
  logic           out_can_load;
  tmf_pkg::triple_t sel_a;
  tmf_pkg::triple_t sel_b;
  tmf_pkg::pix_t  sel_center;
  tmf_pkg::pix_t  sel_pix;
  tmf_pkg::out_item_t res_nxt;
  logic           out_valid_r;
  tmf_pkg::out_item_t out_data_r;

  always_comb begin
    pend_first   = s2_ctl_r.emit1 && !s2_sent1_r;
    pend_any     = pend_first || s2_ctl_r.emit2;
    is_last      = pend_first ? !s2_ctl_r.emit2 : 1'b1;
    out_can_load = !out_valid_r || !out_stall;
    out_load     = s2_valid_r && pend_any && out_can_load;
    s2_free      = !s2_valid_r || !pend_any || (out_load && is_last);
    sel_a        = pend_first ? cell_srt[0] : cell_srt[1];
    sel_b        = pend_first ? cell_srt[1] : cell_srt[2];
    sel_center   = pend_first ? cell_col[1].mid : cell_col[2].mid;
  end

  tmf_select u_select (
    .col_a     (sel_a),
    .col_b     (sel_b),
    .col_c     (cell_srt[2]),
    .center    (sel_center),
    .threshold (threshold_r),
    .pix       (sel_pix)
  );

  always_comb begin
    res_nxt.pixel_out    = sel_pix;
    res_nxt.last_of_run  = pend_first ? s2_ctl_r.last1 : 1'b1;
    res_nxt.end_of_frame = pend_first ? 1'b0 : s2_ctl_r.drain;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s2_sent1_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
        s2_sent1_r <= 1'b0;
      end else begin
        if (s2_free) begin
          s2_valid_r <= 1'b0;
        end
        if (out_load && pend_first) begin
          s2_sent1_r <= 1'b1;
        end
      end
      if (out_can_load) begin
        out_valid_r <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ctl_r <= s1_ctl_r;
    end
    if (out_load) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/tmf_checker.sv
// Port-level checker for the filter unit, attached to the top level by bind.
// Depends on tmf_pkg and the assertion macros header.
`include "threshold_median_filter_3x3_unit_macros.svh"

module tmf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tmf_pkg::out_item_t out_data
);

  logic seen_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_in_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      seen_in_r <= 1'b1;
    end
  end

  `TMF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TMF_ASSERT_IMPL(a_eof_is_last, clk, rst_n, out_valid && out_data.end_of_frame, out_data.last_of_run, "frame end on a result that is not the last of its item")
  `TMF_ASSERT_IMPL(a_no_early_result, clk, rst_n, !seen_in_r, !out_valid, "result before any input transfer")

endmodule

bind threshold_median_filter_3x3_unit tmf_checker u_tmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
